>>> rtl/mbe_pkg.sv
// Shared types and constants for the Mandelbrot escape-time unit.
`default_nettype none
package mbe_pkg;

   localparam int FRAC_BITS   = 27;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_W  = 5;

   // Largest iteration count per pixel
   localparam logic [8:0] ITER_MAX = 9'd256;

   // Register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_START_X      = 3'd0;
   localparam logic [2:0] REG_START_Y      = 3'd1;
   localparam logic [2:0] REG_STEP_SIZE    = 3'd2;
   localparam logic [2:0] REG_MAX_ITER     = 3'd3;
   localparam logic [2:0] REG_ESCAPE_LIMIT = 3'd4;

   // Register reset values
   localparam logic [31:0] START_X_RESET      = 32'd0;
   localparam logic [31:0] START_Y_RESET      = 32'd0;
   localparam logic [30:0] STEP_SIZE_RESET    = 31'd0;
   localparam logic [8:0]  MAX_ITER_RESET     = 9'd256;
   localparam logic [30:0] ESCAPE_LIMIT_RESET = 31'd671088640;

   // One classified pixel: the point c and its starting count
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [8:0]         count;
   } c_word_type;

endpackage
`default_nettype wire

>>> rtl/mandelbrot_escape_time_unit.sv
// Top level: register file, front stage, queue and iteration engine.
// Path from input accept to rsp_valid: the front stage register, the queue, and then,
// per iteration (1 to 256 run per pixel), a multiply state and an add-and-test state.
// The single multiplier set iterates one pixel at a time and takes the next only when idle.
// Reset (synchronous, active high) empties all stages and loads register
// defaults: max_iter 256, escape_limit 5.0, others zero.
`default_nettype none
module mandelbrot_escape_time_unit #(
   parameter int QUEUE_DEPTH = mbe_pkg::QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [9:0]                    req_row,
   input  wire logic [9:0]                    req_col,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_depth,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [mbe_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic signed [31:0] start_x_ff, start_y_ff;
   logic [30:0]        step_size_ff, escape_limit_ff;
   logic [8:0]         max_iter_ff;
   logic [2:0]         reg_index;
   logic               csr_write;

   logic                f_valid, f_ready, q_valid, q_ready;
   mbe_pkg::c_word_type f_word, q_word;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff      <= mbe_pkg::START_X_RESET;
         start_y_ff      <= mbe_pkg::START_Y_RESET;
         step_size_ff    <= mbe_pkg::STEP_SIZE_RESET;
         max_iter_ff     <= mbe_pkg::MAX_ITER_RESET;
         escape_limit_ff <= mbe_pkg::ESCAPE_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            mbe_pkg::REG_START_X:      start_x_ff      <= pwdata;
            mbe_pkg::REG_START_Y:      start_y_ff      <= pwdata;
            mbe_pkg::REG_STEP_SIZE:    step_size_ff    <= pwdata[30:0];
            mbe_pkg::REG_MAX_ITER:     max_iter_ff     <= pwdata[8:0];
            mbe_pkg::REG_ESCAPE_LIMIT: escape_limit_ff <= pwdata[30:0];
            default: begin
               // drop writes to unmapped addresses
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         mbe_pkg::REG_START_X:      prdata = start_x_ff;
         mbe_pkg::REG_START_Y:      prdata = start_y_ff;
         mbe_pkg::REG_STEP_SIZE:    prdata = 32'(step_size_ff);
         mbe_pkg::REG_MAX_ITER:     prdata = 32'(max_iter_ff);
         mbe_pkg::REG_ESCAPE_LIMIT: prdata = 32'(escape_limit_ff);
         default:                   prdata = 32'd0;
      endcase
   end

   mbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_row    (req_row),
      .req_col    (req_col),
      .start_x    (start_x_ff),
      .start_y    (start_y_ff),
      .step_size  (step_size_ff),
      .max_iter   (max_iter_ff),
      .word_valid (f_valid),
      .word_ready (f_ready),
      .word       (f_word)
   );

   mbe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_word   (f_word),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_word  (q_word)
   );

   mbe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .word_valid   (q_valid),
      .word_ready   (q_ready),
      .word         (q_word),
      .escape_limit (escape_limit_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_depth    (rsp_depth)
   );

endmodule
`default_nettype wire

>>> rtl/mbe_front.sv
// Front stage: accepts a pixel, maps it to the point c and clamps the count.
`default_nettype none
module mbe_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [9:0]         req_row,
   input  wire logic [9:0]         req_col,
   input  wire logic signed [31:0] start_x,
   input  wire logic signed [31:0] start_y,
   input  wire logic [30:0]        step_size,
   input  wire logic [8:0]         max_iter,
   output logic                    word_valid,
   input  wire logic               word_ready,
   output mbe_pkg::c_word_type     word
);

   logic                valid_ff, valid_in;
   mbe_pkg::c_word_type word_ff, word_in;
   logic [40:0]         col_prod, row_prod;
   logic                take;

   assign req_ready  = !valid_ff || word_ready;
   assign take       = req_valid && req_ready;
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_comb begin
      col_prod = 41'(req_col) * 41'(step_size);
      row_prod = 41'(req_row) * 41'(step_size);
      word_in.cx = start_x - $signed(col_prod[31:0]);
      word_in.cy = start_y - $signed(row_prod[31:0]);
      priority if (max_iter == 9'd0) begin
         word_in.count = 9'd1;
      end else if (max_iter > mbe_pkg::ITER_MAX) begin
         word_in.count = mbe_pkg::ITER_MAX;
      end else begin
         word_in.count = max_iter;
      end
      valid_in = take || (valid_ff && !word_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/mbe_queue.sv
// Small FIFO between the front stage and the iteration engine.
`default_nettype none
module mbe_queue #(
   parameter int DEPTH = mbe_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire mbe_pkg::c_word_type  in_word,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output mbe_pkg::c_word_type       out_word
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mbe_pkg::c_word_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                push, pop;

   assign in_ready  = cnt_ff != CNT_W'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue fill count above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty with pointers apart");

endmodule
`default_nettype wire

>>> rtl/mbe_back.sv
// Iteration engine: runs z = z*z + c for one pixel and holds the depth.
`default_nettype none
module mbe_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                word_valid,
   output logic                     word_ready,
   input  wire mbe_pkg::c_word_type word,
   input  wire logic [30:0]         escape_limit,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_depth
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_ADD  = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in, cx_ff, cx_in, cy_ff, cy_in;
   logic [8:0]         count_ff, count_in;
   logic signed [63:0] xx_ff, yy_ff, xy_ff;
   logic signed [63:0] x2, y2, xy2;
   logic signed [64:0] mag;
   logic               go, out_free, out_load;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         depth_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign word_ready = state_ff == S_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_depth  = depth_ff;

   always_comb begin
      x2  = xx_ff >>> mbe_pkg::FRAC_BITS;
      y2  = yy_ff >>> mbe_pkg::FRAC_BITS;
      xy2 = xy_ff >>> (mbe_pkg::FRAC_BITS - 1);
      mag = 65'(x2) + 65'(y2);
      go  = (count_ff != 9'd1) && (mag < $signed({34'd0, escape_limit}));
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      count_in = count_ff;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (word_valid) begin
               x_in     = word.cx;
               y_in     = word.cy;
               cx_in    = word.cx;
               cy_in    = word.cy;
               count_in = word.count;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            x_in     = x2[31:0] - y2[31:0] + cx_ff;
            y_in     = xy2[31:0] + cy_ff;
            count_in = count_ff - 1'b1;
            if (go) begin
               state_in = S_MUL;
            end else if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            // wait for the output register to drain
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      count_ff <= count_in;
      if (state_ff == S_MUL) begin
         xx_ff <= 64'(x_ff) * 64'(x_ff);
         yy_ff <= 64'(y_ff) * 64'(y_ff);
         xy_ff <= 64'(x_ff) * 64'(y_ff);
      end
      if (out_load) begin
         depth_ff <= (state_ff == S_HOLD) ? count_ff[7:0] : count_in[7:0];
      end
   end

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL || state_ff == S_ADD) |-> (count_ff != 9'd0))
      else $error("iterating with zero count");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result word overwritten");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (word_valid && word_ready) |=> (state_ff == S_MUL))
      else $error("popped word did not start iteration");

endmodule
`default_nettype wire
